/* src/lwkd_pkg.sv */
// Shared types and constants for the longest-window-with-k-distinct block.
// Used by lwkd_front, lwkd_back and longest_window_k_distinct; no dependencies.
package lwkd_pkg;

   localparam int WINDOW_DEPTH_DEF = 1024;
   localparam int SYM_W            = 8;
   localparam int SYM_VALUES       = 256;
   localparam int DIST_W           = 9;
   localparam int LONGEST_W        = 11;

   localparam logic [DIST_W-1:0] MAX_DISTINCT_RST = 9'd1;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } lwkd_item_type;

   typedef struct packed {
      logic [LONGEST_W-1:0] longest;
      logic                 overflow;
   } lwkd_result_type;

endpackage

/* src/lwkd_front.sv */
// Front end: accepts input beats into a two-entry queue that decouples
// the request port from the window engine. Depends on lwkd_pkg.
module lwkd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lwkd_pkg::lwkd_item_type push_item,
   output logic                   full,
   output logic                   item_valid,
   output lwkd_pkg::lwkd_item_type item,
   input  logic                   item_take
);

   lwkd_pkg::lwkd_item_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   logic       pop_ok;

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = ent_ff[rd_ptr_ff];
   assign push_ok    = push & ~full;
   assign pop_ok     = item_take & item_valid;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push_ok, pop_ok})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/lwkd_back.sv */
// Back end: sliding-window engine with the byte store, the per-value count
// table and the line result. Depends on lwkd_pkg.
module lwkd_back #(
   parameter int WINDOW_DEPTH = lwkd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lwkd_pkg::DIST_W-1:0]       max_distinct,
   input  logic                              item_valid,
   input  lwkd_pkg::lwkd_item_type           item,
   output logic                              item_take,
   input  logic                              res_ready,
   output logic                              res_valid,
   output lwkd_pkg::lwkd_result_type         res
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(WINDOW_DEPTH);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_PUSH_RD = 3'd1;
   localparam logic [2:0] S_PUSH_WR = 3'd2;
   localparam logic [2:0] S_EV_RD   = 3'd3;
   localparam logic [2:0] S_EV_CNT  = 3'd4;
   localparam logic [2:0] S_EV_WR   = 3'd5;
   localparam logic [2:0] S_BEST    = 3'd6;

   logic [2:0]                       state_ff, state_in;
   logic [lwkd_pkg::SYM_W-1:0]       sym_ff, sym_in;
   logic                             last_ff, last_in;
   logic                             refill_ff, refill_in;
   logic [IDX_W-1:0]                 head_ff, head_in;
   logic [IDX_W-1:0]                 tail_ff, tail_in;
   logic [LEN_W-1:0]                 len_ff, len_in;
   logic [lwkd_pkg::DIST_W-1:0]      distinct_ff, distinct_in;
   logic [LEN_W-1:0]                 best_ff, best_in;
   logic                             ovf_ff, ovf_in;
   logic [lwkd_pkg::SYM_VALUES-1:0]  cnt_vld_ff;

   logic [LEN_W-1:0]                 cnt_mem [lwkd_pkg::SYM_VALUES];
   logic [lwkd_pkg::SYM_W-1:0]       sto_mem [WINDOW_DEPTH];
   logic [LEN_W-1:0]                 cnt_q_ff;
   logic                             cnt_qv_ff;
   logic [lwkd_pkg::SYM_W-1:0]       sto_q_ff;

   logic [lwkd_pkg::SYM_W-1:0]       cnt_raddr;
   logic                             cnt_we;
   logic [lwkd_pkg::SYM_W-1:0]       cnt_waddr;
   logic [LEN_W-1:0]                 cnt_wdata;
   logic                             sto_we;
   logic                             line_clear;
   logic [LEN_W-1:0]                 cnt_cur;
   logic [LEN_W-1:0]                 best_upd;
   logic [LEN_W+lwkd_pkg::LONGEST_W-1:0] best_ext;

   assign cnt_cur   = cnt_qv_ff ? cnt_q_ff : '0;
   assign best_upd  = (len_ff > best_ff) ? len_ff : best_ff;
   assign best_ext  = {{lwkd_pkg::LONGEST_W{1'b0}}, best_upd};
   assign cnt_raddr = (state_ff == S_PUSH_RD) ? sym_ff : sto_q_ff;

   always_comb begin
      state_in    = state_ff;
      sym_in      = sym_ff;
      last_in     = last_ff;
      refill_in   = refill_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      len_in      = len_ff;
      distinct_in = distinct_ff;
      best_in     = best_ff;
      ovf_in      = ovf_ff;
      item_take   = 1'b0;
      res_valid   = 1'b0;
      res.longest = best_ext[lwkd_pkg::LONGEST_W-1:0];
      res.overflow = ovf_ff;
      cnt_we      = 1'b0;
      cnt_waddr   = sym_ff;
      cnt_wdata   = cnt_cur + LEN_W'(1);
      sto_we      = 1'b0;
      line_clear  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               sym_in    = item.symbol;
               last_in   = item.last;
               // full window: drop the oldest byte before the new one goes in
               if (len_ff == LEN_FULL) begin
                  ovf_in    = 1'b1;
                  refill_in = 1'b1;
                  state_in  = S_EV_RD;
               end else begin
                  state_in  = S_PUSH_RD;
               end
            end
         end
         S_PUSH_RD: begin
            sto_we   = 1'b1;
            head_in  = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
            state_in = S_PUSH_WR;
         end
         S_PUSH_WR: begin
            cnt_we      = 1'b1;
            len_in      = len_ff + LEN_W'(1);
            distinct_in = (cnt_cur == '0) ? distinct_ff + lwkd_pkg::DIST_W'(1)
                                          : distinct_ff;
            state_in    = (distinct_in > max_distinct) ? S_EV_RD : S_BEST;
         end
         S_EV_RD: begin
            state_in = S_EV_CNT;
         end
         S_EV_CNT: begin
            state_in = S_EV_WR;
         end
         S_EV_WR: begin
            cnt_we      = 1'b1;
            cnt_waddr   = sto_q_ff;
            cnt_wdata   = cnt_cur - LEN_W'(1);
            len_in      = len_ff - LEN_W'(1);
            distinct_in = (cnt_cur == LEN_W'(1)) ? distinct_ff - lwkd_pkg::DIST_W'(1)
                                                 : distinct_ff;
            tail_in     = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_W'(1);
            if (refill_ff) begin
               refill_in = 1'b0;
               state_in  = S_PUSH_RD;
            end else if (distinct_in > max_distinct && len_in != '0) begin
               state_in  = S_EV_RD;
            end else begin
               state_in  = S_BEST;
            end
         end
         S_BEST: begin
            if (!last_ff) begin
               best_in  = best_upd;
               state_in = S_IDLE;
            end else if (res_ready) begin
               res_valid   = 1'b1;
               line_clear  = 1'b1;
               head_in     = '0;
               tail_in     = '0;
               len_in      = '0;
               distinct_in = '0;
               best_in     = '0;
               ovf_in      = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         refill_ff   <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         len_ff      <= '0;
         distinct_ff <= '0;
         best_ff     <= '0;
         ovf_ff      <= 1'b0;
         cnt_vld_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         refill_ff   <= refill_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         len_ff      <= len_in;
         distinct_ff <= distinct_in;
         best_ff     <= best_in;
         ovf_ff      <= ovf_in;
         if (line_clear) begin
            cnt_vld_ff <= '0;
         end else if (cnt_we) begin
            cnt_vld_ff[cnt_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      last_ff <= last_in;
   end

   // count table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_q_ff  <= cnt_mem[cnt_raddr];
      cnt_qv_ff <= cnt_vld_ff[cnt_raddr];
   end

   // window store: write at head, registered read at tail
   always_ff @(posedge clock) begin
      if (sto_we) begin
         sto_mem[head_ff] <= sym_ff;
      end
      sto_q_ff <= sto_mem[tail_ff];
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("window length above store depth");

   a_distinct_le_len: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(distinct_ff) <= len_ff || distinct_ff <= lwkd_pkg::DIST_W'(len_ff))
      else $error("more distinct values than bytes in window");

   a_evict_counted: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EV_WR |-> cnt_qv_ff && cnt_q_ff != '0)
      else $error("evicted byte has no count");

   a_line_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BEST && last_ff && res_ready)
         |=> (len_ff == '0 && distinct_ff == '0 && best_ff == '0 && cnt_vld_ff == '0))
      else $error("window not drained after line end");

endmodule

/* src/longest_window_k_distinct.sv */
// Longest run of a text line with at most max_distinct byte values: top level.
// Depends on lwkd_pkg, lwkd_front and lwkd_back.
//
// Each request beat carries one byte and a last-of-line flag; one response
// beat (longest window length and overflow flag) comes out per line, after
// its last byte, and the window then starts empty for the next line. A byte
// goes through the push states of the window engine (S_PUSH_RD, S_PUSH_WR,
// S_BEST) plus the evict states (S_EV_RD, S_EV_CNT, S_EV_WR) for every older
// byte it pushes out of the window; these steps come from the registered
// read of the count table, whose read-modify-write each window update goes
// through. A two-entry request queue keeps taking bytes while the engine
// works, until it is full, and a one-beat response register holds a result
// until popped. csr_max_distinct may be written only while idle.
module longest_window_k_distinct #(
   parameter int WINDOW_DEPTH = lwkd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  logic [lwkd_pkg::SYM_W-1:0]         req_symbol,
   input  logic                               req_last,
   output logic                               req_full,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [lwkd_pkg::LONGEST_W-1:0]     rsp_longest,
   output logic                               rsp_overflow,
   input  logic                               csr_we,
   input  logic [lwkd_pkg::DIST_W-1:0]        csr_max_distinct
);

   logic [lwkd_pkg::DIST_W-1:0] max_distinct_ff;
   lwkd_pkg::lwkd_item_type     push_item;
   lwkd_pkg::lwkd_item_type     item;
   logic                        item_valid;
   logic                        item_take;
   logic                        res_valid;
   lwkd_pkg::lwkd_result_type   res;
   logic                        rsp_valid_ff, rsp_valid_in;
   lwkd_pkg::lwkd_result_type   rsp_res_ff;
   logic                        rsp_free;

   assign push_item.symbol = req_symbol;
   assign push_item.last   = req_last;

   lwkd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_item  (push_item),
      .full       (req_full),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   lwkd_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .max_distinct (max_distinct_ff),
      .item_valid   (item_valid),
      .item         (item),
      .item_take    (item_take),
      .res_ready    (rsp_free),
      .res_valid    (res_valid),
      .res          (res)
   );

   // hold the result until popped; a pop frees the slot in the same cycle
   assign rsp_free     = ~rsp_valid_ff | rsp_pop;
   assign rsp_valid_in = res_valid | (rsp_valid_ff & ~rsp_pop);
   assign rsp_empty    = ~rsp_valid_ff;
   assign rsp_longest  = rsp_res_ff.longest;
   assign rsp_overflow = rsp_res_ff.overflow;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         max_distinct_ff <= lwkd_pkg::MAX_DISTINCT_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_distinct_ff <= csr_max_distinct;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_res_ff <= res;
      end
   end

endmodule

/* test/lwkd_checker.sv */
// Scoreboard for longest_window_k_distinct: mirrors the sliding window per line
// and compares each response beat against the predicted longest/overflow pair.
// Depends on lwkd_pkg only; watches the request, response and csr ports.
`timescale 1ns / 1ps

module lwkd_checker #(
   parameter int WINDOW_DEPTH = lwkd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  logic [lwkd_pkg::SYM_W-1:0]     req_symbol,
   input  logic                           req_last,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  logic [lwkd_pkg::LONGEST_W-1:0] rsp_longest,
   input  logic                           rsp_overflow,
   input  logic                           csr_we,
   input  logic [lwkd_pkg::DIST_W-1:0]    csr_max_distinct,
   output int                             fail_count,
   output int                             pending_count,
   output int                             bytes_taken,
   output int                             lines_checked,
   output int                             overflow_lines
);

   logic [lwkd_pkg::LONGEST_W-1:0] sym_count [lwkd_pkg::SYM_VALUES];
   logic [lwkd_pkg::SYM_W-1:0]     window_mem [WINDOW_DEPTH];
   int                             oldest_pos;
   int                             newest_pos;
   logic [lwkd_pkg::LONGEST_W-1:0] win_len;
   logic [lwkd_pkg::LONGEST_W-1:0] best_len;
   logic [lwkd_pkg::DIST_W-1:0]    distinct_vals;
   logic [lwkd_pkg::DIST_W-1:0]    limit;
   logic                           overflow_hit;
   lwkd_pkg::lwkd_result_type      line_result_q [$];
   int                             fails = 0;
   int                             n_bytes = 0;
   int                             n_lines = 0;
   int                             n_ovf = 0;

   function automatic void clear_line();
      foreach (sym_count[i]) sym_count[i] = '0;
      oldest_pos    = 0;
      newest_pos    = 0;
      win_len       = '0;
      best_len      = '0;
      distinct_vals = '0;
      overflow_hit  = 1'b0;
   endfunction

   function automatic void drop_oldest();
      logic [lwkd_pkg::SYM_W-1:0] v;
      v = window_mem[oldest_pos];
      if (sym_count[v] != 0) begin
         sym_count[v] = sym_count[v] - 1'b1;
         if (sym_count[v] == 0 && distinct_vals != 0)
            distinct_vals = distinct_vals - 1'b1;
      end
      oldest_pos = (oldest_pos + 1) % WINDOW_DEPTH;
      win_len    = win_len - 1'b1;
   endfunction

   always @(posedge clock) begin : track
      lwkd_pkg::lwkd_result_type  want;
      logic [lwkd_pkg::SYM_W-1:0] sym;
      if (reset) begin
         limit = lwkd_pkg::MAX_DISTINCT_RST;
         clear_line();
         line_result_q.delete();
      end else begin
         if (csr_we)
            limit = csr_max_distinct;

         // compare before predicting: a beat popped now can never belong to a byte taken now
         if (rsp_pop && !rsp_empty) begin
            if (line_result_q.size() == 0) begin
               if (fails < 10)
                  $display("%0t: response beat with nothing pending: longest %0d overflow %0b",
                           $realtime, rsp_longest, rsp_overflow);
               fails++;
            end else begin
               want = line_result_q.pop_front();
               if (rsp_longest !== want.longest || rsp_overflow !== want.overflow) begin
                  if (fails < 10)
                     $display("%0t: line %0d longest exp %0d got %0d, overflow exp %0b got %0b",
                              $realtime, n_lines, want.longest, rsp_longest,
                              want.overflow, rsp_overflow);
                  fails++;
               end
               if (want.overflow)
                  n_ovf++;
               n_lines++;
            end
         end

         if (req_push && !req_full) begin
            sym = req_symbol;
            n_bytes++;
            // full window: push the oldest byte out first
            if (win_len >= WINDOW_DEPTH) begin
               overflow_hit = 1'b1;
               drop_oldest();
            end
            window_mem[newest_pos] = sym;
            newest_pos = (newest_pos + 1) % WINDOW_DEPTH;
            win_len    = win_len + 1'b1;
            if (sym_count[sym] == 0)
               distinct_vals = distinct_vals + 1'b1;
            sym_count[sym] = sym_count[sym] + 1'b1;
            while (distinct_vals > limit && win_len != 0)
               drop_oldest();
            if (win_len > best_len)
               best_len = win_len;
            if (req_last) begin
               want.longest  = best_len;
               want.overflow = overflow_hit;
               line_result_q.push_back(want);
               clear_line();
            end
         end
      end
      fail_count     <= fails;
      pending_count  <= line_result_q.size();
      bytes_taken    <= n_bytes;
      lines_checked  <= n_lines;
      overflow_lines <= n_ovf;
   end

endmodule

/* test/tb_longest_window_k_distinct.sv */
// Top of the longest_window_k_distinct bench: clock, reset, byte-line stimulus,
// response popping with random stalls, limit changes and the final verdict.
// Depends on lwkd_pkg, lwkd_checker and the longest_window_k_distinct RTL.
`timescale 1ns / 1ps

module tb_longest_window_k_distinct;

   localparam int DEPTH        = lwkd_pkg::WINDOW_DEPTH_DEF;
   // one byte may push a whole window out, one eviction after another
   localparam int IDLE_WAIT    = 4 * DEPTH + 64;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_BYTES = 750;
   localparam int RAND_PHASES  = 6;
   localparam int HOLD_CYCLES  = 600;
   localparam int LONG_LINE    = DEPTH + 6;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic [lwkd_pkg::SYM_W-1:0]     req_symbol = '0;
   logic                           req_last = 1'b0;
   logic                           req_full;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic [lwkd_pkg::LONGEST_W-1:0] rsp_longest;
   logic                           rsp_overflow;
   logic                           csr_we = 1'b0;
   logic [lwkd_pkg::DIST_W-1:0]    csr_max_distinct = '0;

   int fail_count;
   int pending_count;
   int bytes_taken;
   int lines_checked;
   int overflow_lines;
   int cycle_count;
   bit tx_burst = 1'b0;
   bit hold_armed = 1'b0;

   longest_window_k_distinct #(
      .WINDOW_DEPTH(DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_symbol      (req_symbol),
      .req_last        (req_last),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_longest     (rsp_longest),
      .rsp_overflow    (rsp_overflow),
      .csr_we          (csr_we),
      .csr_max_distinct(csr_max_distinct)
   );

   lwkd_checker #(
      .WINDOW_DEPTH(DEPTH)
   ) chk (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_symbol      (req_symbol),
      .req_last        (req_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_longest     (rsp_longest),
      .rsp_overflow    (rsp_overflow),
      .csr_we          (csr_we),
      .csr_max_distinct(csr_max_distinct),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .bytes_taken     (bytes_taken),
      .lines_checked   (lines_checked),
      .overflow_lines  (overflow_lines)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_count);
      $display("FAILED: results differ");
      $finish;
   end

   // returns on the edge where the beat was taken; push stays high for the caller
   task automatic send_byte(input logic [lwkd_pkg::SYM_W-1:0] sym, input logic last);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push   <= 1'b1;
      req_symbol <= sym;
      req_last   <= last;
      do @(negedge clock); while (req_full);
      @(posedge clock);
   endtask

   // drop push, wait out every pending result and the engine's last byte
   task automatic wait_idle();
      req_push <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic set_limit(input logic [lwkd_pkg::DIST_W-1:0] value);
      wait_idle();
      csr_we           <= 1'b1;
      csr_max_distinct <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_line(input logic [lwkd_pkg::SYM_W-1:0] base, input int alpha,
                            input int len);
      for (int i = 0; i < len; i++)
         send_byte(lwkd_pkg::SYM_W'(base + $urandom_range(0, alpha - 1)), i == len - 1);
   endtask

   // response side: random stalls, bursts of back-to-back pops, one long hold-off
   initial begin : popper
      int gap;
      int beats;
      bit burst;
      bit held;
      beats = 0;
      burst = 1'b0;
      held  = 1'b0;
      forever begin
         if (hold_armed && !held) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            continue;
         end
         if (beats % 32 == 0)
            burst = ($urandom_range(0, 3) == 0);
         gap = burst ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(negedge clock); while (rsp_empty);
         @(posedge clock);
         beats++;
      end
   end

   initial begin : stimulus
      logic [lwkd_pkg::DIST_W-1:0] phase_limit [RAND_PHASES];
      int sent;
      int kind;
      int len;
      int alpha;
      phase_limit = '{9'd3, 9'd1, 9'd0, 9'd511, 9'd2, 9'd0};
      phase_limit[5] = lwkd_pkg::DIST_W'($urandom_range(4, 257));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset limit of one: symbol extremes, repeats extend the run
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hA5, 1'b1);

      // limit zero: every byte is evicted at once
      set_limit(9'd0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h02, 1'b1);

      // limit above the symbol range never shrinks the window
      set_limit(9'd511);
      send_byte(8'h10, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h13, 1'b1);

      // lower the limit in the middle of a line
      set_limit(9'd2);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      set_limit(9'd1);
      send_byte(8'h63, 1'b0);
      send_byte(8'h63, 1'b1);

      // a line longer than the store forces the overflow path
      set_limit(9'd256);
      tx_burst = 1'b1;
      send_line(lwkd_pkg::SYM_W'($urandom_range(0, 255)), 256, LONG_LINE);
      tx_burst = 1'b0;

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         set_limit(phase_limit[ph]);
         tx_burst = ($urandom_range(0, 2) == 0);
         if (ph == 1)
            hold_armed = 1'b1;
         sent = 0;
         while (sent < RANDOM_BYTES / RAND_PHASES) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
               len   = $urandom_range(1, 16);
               alpha = $urandom_range(1, 6);
            end else if (kind <= 8) begin
               len   = $urandom_range(17, 60);
               alpha = $urandom_range(2, 12);
            end else begin
               len   = $urandom_range(1, 10);
               alpha = 256;
            end
            send_line(lwkd_pkg::SYM_W'($urandom_range(0, 255)), alpha, len);
            sent += len;
         end
      end

      wait_idle();
      $display("Run covered %0d bytes in %0d lines (%0d with window overflow),",
               bytes_taken, lines_checked, overflow_lines);
      $display("limits 0, 1, 2, 3, 256, 511 and one random, with a mid-line change.");
      if (fail_count == 0 && pending_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* files.f */
src/lwkd_pkg.sv
src/lwkd_front.sv
src/lwkd_back.sv
src/longest_window_k_distinct.sv
test/lwkd_checker.sv
test/tb_longest_window_k_distinct.sv
